// ----- src/pdc_pkg.sv -----
// Shared types, register indexes, result codes and CRC step functions for the
// packet deframer. Depends on nothing; every other file imports it.
`default_nettype none

package pdc_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_POLY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_INIT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PLD_POLY   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PLD_INIT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PLD    = 3'd5;

    // Register reset values.
    localparam logic [7:0]  RST_PREFIX   = 8'hAA;
    localparam logic [7:0]  RST_HDR_POLY = 8'h37;
    localparam logic [7:0]  RST_HDR_INIT = 8'h42;
    localparam logic [15:0] RST_PLD_POLY = 16'h3D65;
    localparam logic [15:0] RST_PLD_INIT = 16'h1337;
    localparam logic [6:0]  RST_MAX_PLD  = 7'd127;

    // Bit of the length byte that marks an oversized length.
    localparam int LEN_TOO_BIG_BIT = 7;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_OK   = 2'd1,
        KIND_DROP = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    // Receive phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    // Header CRC cache rebuild sequence.
    typedef enum logic [1:0] {
        RC_IDLE = 2'd0,
        RC_X    = 2'd1,
        RC_Y    = 2'd2
    } t_recalc;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  prefix;
        logic [7:0]  hdr_poly;
        logic [7:0]  hdr_init;
        logic [15:0] pld_poly;
        logic [15:0] pld_init;
        logic [6:0]  max_pld;
    } t_cfg;

    // Header verdict for the byte now at the window input.
    typedef struct packed {
        logic       accept;
        logic [6:0] length;
    } t_hdr_res;

    // One byte of an MSB-first CRC8.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // One byte of an MSB-first CRC16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/packet_deframer_crc8_crc16_core.sv -----
// Packet deframer with CRC8 header check and CRC16 trailer check, top level.
// Uses pdc_pkg, pdc_cfg_regs, pdc_in_reg, pdc_hdr_window and pdc_frame_ctl.
//
// Input stream: one received byte per transfer on s_axis_tdata, with
// s_axis_tuser high for a stream error instead of a byte. Output stream:
// m_axis_tuser gives the kind (payload byte, frame ok, frame dropped on CRC,
// stream error); m_axis_tdata carries the payload byte and, on end events,
// the clipped payload length. Header bytes and the first trailer byte give
// no transfer on the output.
// An input transfer is held in the input register, then goes through the
// header window or CRC16 step into the result register. One input transfer
// is taken in every cycle as long as the result register can hand its
// content on and no header CRC cache rebuild is running.
// Writing the header CRC polynomial or seed triggers a rebuild of the cached
// partial CRC8 values, first RC_X then RC_Y; input is held off during it.
// Reset empties both registers, selects header search and loads the register
// defaults. When the receiver stalls with a result waiting, that result holds
// and the input register takes at most one more transfer before
// s_axis_tready drops.
`default_nettype none

module packet_deframer_crc8_crc16_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic                            s_axis_tuser,   // [0] op
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] data, [14:8] frame_length
    output logic [1:0]                      m_axis_tuser,   // [1:0] kind
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pdc_pkg::*;

    t_cfg       w_cfg;
    logic       w_recalc;
    logic       w_in_valid;
    logic       w_op;
    logic [7:0] w_byte;
    logic       w_fire;
    logic       w_busy;
    logic       w_push;
    logic       w_clear;
    t_hdr_res   w_hdr;

    // An item is processed when the result register is free or draining and no cache rebuild runs.
    assign w_fire = w_in_valid && !w_busy && (!m_axis_tvalid || m_axis_tready);

    pdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg),
        .o_recalc    (w_recalc)
    );

    pdc_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_take     (w_fire),
        .o_valid    (w_in_valid),
        .o_op       (w_op),
        .o_byte     (w_byte)
    );

    pdc_hdr_window u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_recalc (w_recalc),
        .i_push   (w_push),
        .i_clear  (w_clear),
        .i_byte   (w_byte),
        .o_hdr    (w_hdr),
        .o_busy   (w_busy)
    );

    pdc_frame_ctl u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_fire),
        .i_op        (w_op),
        .i_byte      (w_byte),
        .i_hdr       (w_hdr),
        .o_push      (w_push),
        .o_clear     (w_clear),
        .o_out_valid (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- src/pdc_cfg_regs.sv -----
// Configuration register bank of the packet deframer.
// Depends on pdc_pkg for register indexes, reset values and the t_cfg type.
`default_nettype none

module pdc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pdc_pkg::t_cfg                  o_cfg,
    output logic                           o_recalc
);
    import pdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register write decode.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PREFIX:   n_cfg.prefix   = i_cfg_wdata[7:0];
                REG_HDR_POLY: n_cfg.hdr_poly = i_cfg_wdata[7:0];
                REG_HDR_INIT: n_cfg.hdr_init = i_cfg_wdata[7:0];
                REG_PLD_POLY: n_cfg.pld_poly = i_cfg_wdata;
                REG_PLD_INIT: n_cfg.pld_init = i_cfg_wdata;
                REG_MAX_PLD:  n_cfg.max_pld  = i_cfg_wdata[6:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix   <= RST_PREFIX;
            r_cfg.hdr_poly <= RST_HDR_POLY;
            r_cfg.hdr_init <= RST_HDR_INIT;
            r_cfg.pld_poly <= RST_PLD_POLY;
            r_cfg.pld_init <= RST_PLD_INIT;
            r_cfg.max_pld  <= RST_MAX_PLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    // A new header polynomial or seed makes the cached partial CRCs stale.
    assign o_recalc = i_cfg_we && ((i_cfg_addr == REG_HDR_POLY) || (i_cfg_addr == REG_HDR_INIT));

endmodule

`default_nettype wire

// ----- src/pdc_in_reg.sv -----
// Input register stage of the packet deframer: holds one received transfer.
// Depends on pdc_pkg for the input data width.
`default_nettype none

module pdc_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pdc_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_take,
    output logic                           o_valid,
    output logic                           o_op,
    output logic [7:0]                     o_byte
);
    import pdc_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic       r_op;
    logic [7:0] r_byte;
    logic       w_accept;

    // The slot frees up in the same cycle the held item is consumed.
    assign o_s_tready = !r_valid || i_take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_byte <= i_s_tdata[7:0];
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// ----- src/pdc_hdr_window.sv -----
// Three-byte header window with cached partial CRC8 values per position.
// Depends on pdc_pkg for t_cfg, t_hdr_res, t_recalc and crc8_byte.
`default_nettype none

module pdc_hdr_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdc_pkg::t_cfg     i_cfg,
    input  logic              i_recalc,
    input  logic              i_push,
    input  logic              i_clear,
    input  logic [7:0]        i_byte,
    output pdc_pkg::t_hdr_res o_hdr,
    output logic              o_busy
);
    import pdc_pkg::*;

    // r_x[i] is the CRC8 of the seed and byte i; r_y[i] continues r_x[i] over byte i+1.
    logic [7:0] r_win [3];
    logic [7:0] n_win [3];
    logic [7:0] r_x   [3];
    logic [7:0] n_x   [3];
    logic [7:0] r_y   [2];
    logic [7:0] n_y   [2];
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    t_recalc    r_rc;
    t_recalc    n_rc;

    logic [1:0] w_pos;
    logic [7:0] w_new_x;
    logic [7:0] w_new_y;
    logic [7:0] w_hdr_crc;
    logic       w_full;
    logic       w_bad_prefix;
    logic       w_bad_len;

    // Incoming byte position, and the CRC steps that involve it.
    assign w_pos        = (r_fill == 2'd3) ? 2'd2 : r_fill;
    assign w_new_x      = crc8_byte(i_cfg.hdr_init, i_byte, i_cfg.hdr_poly);
    assign w_new_y      = crc8_byte(r_x[1], i_byte, i_cfg.hdr_poly);
    assign w_hdr_crc    = crc8_byte(r_y[0], i_byte, i_cfg.hdr_poly);
    assign w_full       = (w_pos == 2'd2) && (r_rc == RC_IDLE);
    assign w_bad_prefix = (r_win[0] != i_cfg.prefix);
    assign w_bad_len    = r_win[1][LEN_TOO_BIG_BIT];

    // Header verdict for the byte at the input, independent of the push strobe.
    assign o_hdr.accept = w_full && !w_bad_prefix && !w_bad_len && (w_hdr_crc == 8'h00);
    assign o_hdr.length = r_win[1][6:0];
    assign o_busy       = (r_rc != RC_IDLE);

    // Window update, drops and cache rebuild.
    always_comb begin
        n_win  = r_win;
        n_x    = r_x;
        n_y    = r_y;
        n_fill = r_fill;
        n_rc   = r_rc;
        unique case (r_rc)
            RC_X: begin
                for (int i = 0; i < 3; i++) begin
                    n_x[i] = crc8_byte(i_cfg.hdr_init, r_win[i], i_cfg.hdr_poly);
                end
                n_rc = RC_Y;
            end
            RC_Y: begin
                for (int i = 0; i < 2; i++) begin
                    n_y[i] = crc8_byte(r_x[i], r_win[i+1], i_cfg.hdr_poly);
                end
                n_rc = RC_IDLE;
            end
            default: begin
                if (i_push) begin
                    case (w_pos)
                        2'd0: begin
                            n_win[0] = i_byte;
                            n_x[0]   = w_new_x;
                            n_fill   = 2'd1;
                        end
                        2'd1: begin
                            n_win[1] = i_byte;
                            n_x[1]   = w_new_x;
                            n_y[0]   = crc8_byte(r_x[0], i_byte, i_cfg.hdr_poly);
                            n_fill   = 2'd2;
                        end
                        default: begin
                            if (w_bad_prefix) begin
                                // Drop one byte: length and CRC bytes move up.
                                n_win[0] = r_win[1];
                                n_win[1] = i_byte;
                                n_x[0]   = r_x[1];
                                n_x[1]   = w_new_x;
                                n_y[0]   = w_new_y;
                                n_fill   = 2'd2;
                            end else if (w_bad_len) begin
                                // Drop two bytes: only the newest byte stays.
                                n_win[0] = i_byte;
                                n_x[0]   = w_new_x;
                                n_fill   = 2'd1;
                            end else begin
                                // Bad header CRC drops all three; a good header empties too.
                                n_fill = 2'd0;
                            end
                        end
                    endcase
                end
            end
        endcase
        if (i_clear) begin
            n_fill = 2'd0;
        end
        if (i_recalc) begin
            n_rc = RC_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_rc   <= RC_IDLE;
        end else begin
            r_fill <= n_fill;
            r_rc   <= n_rc;
        end
    end

    // Window bytes and cached CRCs are only read below the fill level.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_x   <= n_x;
        r_y   <= n_y;
    end

endmodule

`default_nettype wire

// ----- src/pdc_frame_ctl.sv -----
// Frame phase control, payload CRC16 and the result register of the deframer.
// Depends on pdc_pkg for t_cfg, t_hdr_res, t_phase, t_kind and crc16_byte.
`default_nettype none

module pdc_frame_ctl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdc_pkg::t_cfg                   i_cfg,
    input  logic                            i_fire,
    input  logic                            i_op,
    input  logic [7:0]                      i_byte,
    input  pdc_pkg::t_hdr_res               i_hdr,
    output logic                            o_push,
    output logic                            o_clear,
    output logic                            o_out_valid,
    input  logic                            i_m_tready,
    output logic [pdc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                      o_m_tuser
);
    import pdc_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [6:0]  r_len;
    logic [6:0]  n_len;
    logic [6:0]  r_cnt;
    logic [6:0]  n_cnt;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_trl;
    logic        n_trl;
    logic        r_out_valid;
    logic        n_out_valid;
    t_kind       r_kind;
    t_kind       n_kind;
    logic [7:0]  r_data;
    logic [7:0]  n_data;
    logic [6:0]  r_flen;
    logic [6:0]  n_flen;

    logic [15:0] w_crc_step;
    logic [6:0]  w_cnt_inc;
    logic [6:0]  w_clip_len;

    assign w_crc_step = crc16_byte(r_crc, i_byte, i_cfg.pld_poly);
    assign w_cnt_inc  = r_cnt + 7'd1;
    assign w_clip_len = (i_hdr.length < i_cfg.max_pld) ? i_hdr.length : i_cfg.max_pld;

    // Bytes go to the header window in header phase only.
    assign o_push = i_fire && !i_op && (r_phase != PH_PAYLOAD) && (r_phase != PH_TRAILER);

    // Phase sequencing and result generation.
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_trl       = r_trl;
        n_out_valid = r_out_valid && !i_m_tready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_flen      = r_flen;
        o_clear     = 1'b0;
        if (i_fire) begin
            if (i_op) begin
                // Stream error aborts the frame and re-arms header search.
                n_phase     = PH_HEADER;
                n_len       = 7'd0;
                n_cnt       = 7'd0;
                n_crc       = i_cfg.pld_init;
                n_trl       = 1'b0;
                o_clear     = 1'b1;
                n_out_valid = 1'b1;
                n_kind      = KIND_ERR;
                n_data      = 8'h00;
                n_flen      = 7'd0;
            end else begin
                unique case (r_phase)
                    PH_PAYLOAD: begin
                        n_crc = w_crc_step;
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= r_len) begin
                            n_phase = PH_TRAILER;
                            n_trl   = 1'b0;
                        end
                        n_out_valid = 1'b1;
                        n_kind      = KIND_BYTE;
                        n_data      = i_byte;
                        n_flen      = 7'd0;
                    end
                    PH_TRAILER: begin
                        n_crc = w_crc_step;
                        if (!r_trl) begin
                            n_trl = 1'b1;
                        end else begin
                            n_out_valid = 1'b1;
                            n_kind      = (w_crc_step == 16'h0000) ? KIND_OK : KIND_DROP;
                            n_data      = 8'h00;
                            n_flen      = r_len;
                            n_phase     = PH_HEADER;
                            n_len       = 7'd0;
                            n_cnt       = 7'd0;
                            n_crc       = i_cfg.pld_init;
                            n_trl       = 1'b0;
                            o_clear     = 1'b1;
                        end
                    end
                    default: begin
                        // Header phase; the window judges the byte.
                        if (i_hdr.accept) begin
                            n_len   = w_clip_len;
                            n_cnt   = 7'd0;
                            n_crc   = i_cfg.pld_init;
                            n_trl   = 1'b0;
                            n_phase = (w_clip_len == 7'd0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_len       <= 7'd0;
            r_cnt       <= 7'd0;
            r_crc       <= RST_PLD_INIT;
            r_trl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_trl       <= n_trl;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_flen <= n_flen;
    end

    assign o_out_valid = r_out_valid;
    assign o_m_tuser   = r_kind;
    assign o_m_tdata   = {1'b0, r_flen, r_data};

endmodule

`default_nettype wire

// ----- src/pdc_checker.sv -----
// Port-level checks on the deframer output stream, bound to the top level.
// Depends on pdc_pkg for the result kinds and the output data width.
`default_nettype none

module pdc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);
    import pdc_pkg::*;

    // A stalled result holds its content.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output transfer changed while stalled");

    // Payload byte transfers carry no frame length.
    a_byte_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_BYTE) |-> (m_axis_tdata[14:8] == 7'd0))
        else $error("payload byte transfer with nonzero frame length");

    // End events and stream errors carry a zero data byte.
    a_event_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("event transfer with nonzero data byte");

    // A stream error reports no frame length, and the pad bit stays clear.
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[15] &&
            ((m_axis_tuser != KIND_ERR) || (m_axis_tdata[14:8] == 7'd0)))
        else $error("stream error transfer with frame length or pad bit set");

endmodule

bind packet_deframer_crc8_crc16_core pdc_checker u_pdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
